### src/whdp_pkg.sv
// ----------------------------------------------------------------------------
// WebP header dimension parser package
// Shared types and constants for the RIFF/WebP header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package whdp_pkg;

  localparam int unsigned PAYLOAD_DEPTH = 10;
  localparam int unsigned IDX_W         = 4;
  localparam int unsigned DIM_W         = 25;
  localparam int unsigned SEEN_W        = 5;
  localparam int unsigned OUT_TDATA_W   = 56;

  localparam logic [SEEN_W-1:0] MIN_BYTES = SEEN_W'(30);

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WEBP = 32'h5745_4250;
  localparam logic [31:0] TAG_VP8  = 32'h5650_3820;
  localparam logic [31:0] TAG_VP8L = 32'h5650_384C;
  localparam logic [31:0] TAG_VP8X = 32'h5650_3858;

  localparam logic [7:0] VP8_START0 = 8'h9d;
  localparam logic [7:0] VP8_START1 = 8'h01;
  localparam logic [7:0] VP8_START2 = 8'h2a;
  localparam logic [7:0] VP8L_SIG   = 8'h2f;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_WEBP  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_BAD_CHUNK = 2'd3;

  typedef enum logic [2:0] {
    PH_FILE_HDR,
    PH_CHUNK_HDR,
    PH_SKIP,
    PH_VP8,
    PH_VP8L,
    PH_VP8X,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

  typedef struct packed {
    logic  valid;
    dims_t dims;
  } result_t;

endpackage

`default_nettype wire

### src/webp_header_dims_parser.sv
// The parser state advances once per byte taken from the input register.
// Throughput: one byte per cycle while the result register is free or being drained.
// At most one result per buffer, issued from a registered output stage.
// Reset (rst, synchronous) clears the parse state and both pipeline stages;
// a byte marked tlast also returns the parser to its reset state.
// ----------------------------------------------------------------------------
// WebP header dimension parser
// Byte-stream front end: input register, chunk walker, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module webp_header_dims_parser (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_buffer
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [whdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata // [1:0] status,
                                                        // [26:2] width,
                                                        // [51:27] height
);
  import whdp_pkg::*;

  in_item_t s_item;
  in_item_t item;
  logic     item_valid;
  logic     advance;
  result_t  result;
  logic     out_valid;
  dims_t    out_dims;

  assign s_item.data_byte     = s_axis_tdata;
  assign s_item.end_of_buffer = s_axis_tlast;

  // advance whenever the result register is free or being drained
  assign advance = item_valid && (!out_valid || m_axis_tready);

  whdp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_axis_tvalid),
    .s_ready    (s_axis_tready),
    .s_item     (s_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  whdp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (result.valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      out_dims <= result.dims;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0, out_dims.height, out_dims.width, out_dims.status};

endmodule

`default_nettype wire

### src/whdp_in_reg.sv
// ----------------------------------------------------------------------------
// Input register
// Holds one incoming byte until the parser is free to take it.
// ----------------------------------------------------------------------------
`default_nettype none

module whdp_in_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_valid,
  output logic                    s_ready,
  input  wire whdp_pkg::in_item_t s_item,
  input  wire logic               advance,
  output logic                    item_valid,
  output whdp_pkg::in_item_t      item
);
  import whdp_pkg::*;

  in_item_t item_reg;
  logic     valid_reg;

  assign s_ready    = !valid_reg || advance;
  assign item_valid = valid_reg;
  assign item       = item_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_reg <= 1'b0;
    end else if (s_ready) begin
      valid_reg <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready && s_valid) begin
      item_reg <= s_item;
    end
  end

endmodule

`default_nettype wire

### src/whdp_decode.sv
// ----------------------------------------------------------------------------
// Image chunk decoder
// Turns the leading payload bytes of a VP8, VP8L or VP8X chunk into a
// status and the image dimensions.
// ----------------------------------------------------------------------------
`default_nettype none

module whdp_decode (
  input  wire whdp_pkg::phase_t phase,
  input  wire logic [7:0]       pay [whdp_pkg::PAYLOAD_DEPTH],
  output whdp_pkg::dims_t       dims
);
  import whdp_pkg::*;

  logic [13:0] vp8_w;
  logic [13:0] vp8_h;
  logic [31:0] vp8l_bits;

  assign vp8_w     = {pay[7][5:0], pay[6]};
  assign vp8_h     = {pay[9][5:0], pay[8]};
  assign vp8l_bits = {pay[4], pay[3], pay[2], pay[1]};

  always_comb begin
    dims = '0;
    unique case (phase)
      PH_VP8: begin
        if (pay[3] != VP8_START0 || pay[4] != VP8_START1 || pay[5] != VP8_START2 ||
            vp8_w == '0 || vp8_h == '0) begin
          dims.status = ST_BAD_CHUNK;
        end else begin
          dims.status = ST_FOUND;
          dims.width  = DIM_W'(vp8_w);
          dims.height = DIM_W'(vp8_h);
        end
      end
      PH_VP8L: begin
        if (pay[0] != VP8L_SIG) begin
          dims.status = ST_BAD_CHUNK;
        end else begin
          dims.status = ST_FOUND;
          dims.width  = DIM_W'(vp8l_bits[13:0]) + DIM_W'(1);
          dims.height = DIM_W'(vp8l_bits[27:14]) + DIM_W'(1);
        end
      end
      PH_VP8X: begin
        dims.status = ST_FOUND;
        dims.width  = DIM_W'({pay[6], pay[5], pay[4]}) + DIM_W'(1);
        dims.height = DIM_W'({pay[9], pay[8], pay[7]}) + DIM_W'(1);
      end
      default: begin
        dims = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/whdp_parser.sv
// ----------------------------------------------------------------------------
// RIFF chunk walker
// Steps the header parse by one byte per request and produces at most one
// result per buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module whdp_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               step,
  input  wire whdp_pkg::in_item_t item,
  output whdp_pkg::result_t       result
);
  import whdp_pkg::*;

  phase_t                   phase, phase_next;
  logic [IDX_W-1:0]         field_index, field_index_next;
  logic [31:0]              chunk_tag, chunk_tag_next;
  logic [31:0]              chunk_length, chunk_length_next;
  logic [32:0]              skip_remaining, skip_remaining_next;
  logic [SEEN_W-1:0]        bytes_seen, bytes_seen_next;
  logic                     decision_made, decision_made_next;
  logic                     decision_reported, decision_reported_next;
  dims_t                    held, held_next;
  logic [7:0]               payload_bytes [PAYLOAD_DEPTH];
  logic [7:0]               pay_view [PAYLOAD_DEPTH];
  dims_t                    decoded;
  logic                     decide_now;
  dims_t                    decide_dims;
  logic                     payload_write;
  logic [7:0]               b;
  logic [31:0]              tag_shift;
  logic [32:0]              skip_len;
  logic [IDX_W-1:0]         fi_inc;
  logic                     seen_ok;

  assign b        = item.data_byte;
  assign fi_inc   = field_index + IDX_W'(1);
  assign tag_shift = {chunk_tag[23:0], b};

  // current byte stands in for the entry being written this cycle
  always_comb begin
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      pay_view[i] = (field_index == IDX_W'(i)) ? b : payload_bytes[i];
    end
  end

  whdp_decode u_decode (
    .phase (phase),
    .pay   (pay_view),
    .dims  (decoded)
  );

  // next state
  always_comb begin
    phase_next          = phase;
    field_index_next    = field_index;
    chunk_tag_next      = chunk_tag;
    chunk_length_next   = chunk_length;
    skip_remaining_next = skip_remaining;
    decide_now          = 1'b0;
    decide_dims         = '0;
    payload_write       = 1'b0;
    skip_len            = 33'(chunk_length_next) + 33'(chunk_length_next[0]);

    if (!decision_made) begin
      unique case (phase)
        PH_FILE_HDR: begin
          if (field_index < IDX_W'(4) || field_index >= IDX_W'(8)) begin
            chunk_tag_next = tag_shift;
          end
          field_index_next = fi_inc;
          if (field_index == IDX_W'(3) && chunk_tag_next != TAG_RIFF) begin
            decide_now         = 1'b1;
            decide_dims.status = ST_NOT_WEBP;
          end else if (field_index == IDX_W'(11)) begin
            if (chunk_tag_next != TAG_WEBP) begin
              decide_now         = 1'b1;
              decide_dims.status = ST_NOT_WEBP;
            end else begin
              phase_next        = PH_CHUNK_HDR;
              field_index_next  = '0;
              chunk_tag_next    = '0;
              chunk_length_next = '0;
            end
          end
        end
        PH_CHUNK_HDR: begin
          if (field_index < IDX_W'(4)) begin
            chunk_tag_next = tag_shift;
          end else begin
            chunk_length_next = chunk_length | ({24'b0, b} << {field_index[1:0], 3'b000});
          end
          skip_len = 33'(chunk_length_next) + 33'(chunk_length_next[0]);
          if (field_index < IDX_W'(7)) begin
            field_index_next = fi_inc;
          end else begin
            field_index_next = '0;
            if (chunk_tag_next == TAG_VP8) begin
              phase_next = PH_VP8;
            end else if (chunk_tag_next == TAG_VP8L) begin
              phase_next = PH_VP8L;
            end else if (chunk_tag_next == TAG_VP8X) begin
              phase_next = PH_VP8X;
            end else if (skip_len == '0) begin
              chunk_tag_next    = '0;
              chunk_length_next = '0;
            end else begin
              phase_next          = PH_SKIP;
              skip_remaining_next = skip_len;
            end
          end
        end
        PH_SKIP: begin
          skip_remaining_next = skip_remaining - 33'd1;
          if (skip_remaining == 33'd1) begin
            phase_next        = PH_CHUNK_HDR;
            field_index_next  = '0;
            chunk_tag_next    = '0;
            chunk_length_next = '0;
          end
        end
        PH_VP8, PH_VP8L, PH_VP8X: begin
          payload_write    = 1'b1;
          field_index_next = fi_inc;
          if (fi_inc >= ((phase == PH_VP8L) ? IDX_W'(5) : IDX_W'(PAYLOAD_DEPTH))) begin
            decide_now  = 1'b1;
            decide_dims = decoded;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end

    if (decide_now) begin
      phase_next = PH_DONE;
    end
  end

  // bookkeeping and result
  always_comb begin
    bytes_seen_next        = (bytes_seen < MIN_BYTES) ? bytes_seen + SEEN_W'(1) : bytes_seen;
    seen_ok                = bytes_seen_next >= MIN_BYTES;
    decision_made_next     = decision_made || decide_now;
    held_next              = decide_now ? decide_dims : held;
    decision_reported_next = decision_reported;
    result                 = '0;
    if (!decision_reported) begin
      if (decision_made_next && seen_ok) begin
        result.valid           = step;
        result.dims            = held_next;
        decision_reported_next = 1'b1;
      end else if (item.end_of_buffer) begin
        result.valid       = step;
        result.dims.status = ST_TRUNCATED;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.end_of_buffer)) begin
      phase             <= PH_FILE_HDR;
      field_index       <= '0;
      chunk_tag         <= '0;
      chunk_length      <= '0;
      skip_remaining    <= '0;
      bytes_seen        <= '0;
      decision_made     <= 1'b0;
      decision_reported <= 1'b0;
      held              <= '0;
    end else if (step) begin
      phase             <= phase_next;
      field_index       <= field_index_next;
      chunk_tag         <= chunk_tag_next;
      chunk_length      <= chunk_length_next;
      skip_remaining    <= skip_remaining_next;
      bytes_seen        <= bytes_seen_next;
      decision_made     <= decision_made_next;
      decision_reported <= decision_reported_next;
      held              <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && payload_write && field_index < IDX_W'(PAYLOAD_DEPTH)) begin
      payload_bytes[field_index] <= b;
    end
  end

endmodule

`default_nettype wire

### bench/whdp_dims_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebP header dimension checker
// Watches both stream channels of the parser. Every accepted request byte
// steps a cycle-free model of the RIFF chunk walker. A predicted result is
// compared field by field with the oldest entry on the result channel.
// ----------------------------------------------------------------------------

module whdp_dims_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,
  input  logic                             s_axis_tlast,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic [whdp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output int unsigned                      fail_count,
  output int unsigned                      dims_waiting
);
  import whdp_pkg::*;

  phase_t            phase;
  logic [4:0]        idx;
  logic [31:0]       tag;
  logic [31:0]       clen;
  logic [32:0]       skip_left;
  logic [7:0]        pay [PAYLOAD_DEPTH];
  logic [SEEN_W-1:0] seen;
  logic              decided;
  logic              reported;
  dims_t             held;
  dims_t             pending_dims [$];
  int unsigned       fails = 0;

  task automatic clear_parser();
    phase     = PH_FILE_HDR;
    idx       = '0;
    tag       = '0;
    clen      = '0;
    skip_left = '0;
    seen      = '0;
    decided   = 1'b0;
    reported  = 1'b0;
    held      = '0;
  endtask

  task automatic conclude(input logic [1:0] st, input logic [DIM_W-1:0] w,
                          input logic [DIM_W-1:0] h);
    decided     = 1'b1;
    held.status = st;
    held.width  = (st == ST_FOUND) ? w : '0;
    held.height = (st == ST_FOUND) ? h : '0;
    phase       = PH_DONE;
  endtask

  task automatic open_chunk_header();
    phase = PH_CHUNK_HDR;
    idx   = '0;
    tag   = '0;
    clen  = '0;
  endtask

  task automatic close_payload();
    logic [13:0] w14;
    logic [13:0] h14;
    logic [31:0] bits;
    case (phase)
      PH_VP8: begin
        w14 = {pay[7][5:0], pay[6]};
        h14 = {pay[9][5:0], pay[8]};
        if (pay[3] != VP8_START0 || pay[4] != VP8_START1 || pay[5] != VP8_START2)
          conclude(ST_BAD_CHUNK, '0, '0);
        else if (w14 == '0 || h14 == '0)
          conclude(ST_BAD_CHUNK, '0, '0);
        else
          conclude(ST_FOUND, DIM_W'(w14), DIM_W'(h14));
      end
      PH_VP8L: begin
        bits = {pay[4], pay[3], pay[2], pay[1]};
        if (pay[0] != VP8L_SIG)
          conclude(ST_BAD_CHUNK, '0, '0);
        else
          conclude(ST_FOUND, DIM_W'(bits[13:0]) + 1'b1, DIM_W'(bits[27:14]) + 1'b1);
      end
      default: begin
        conclude(ST_FOUND, DIM_W'({pay[6], pay[5], pay[4]}) + 1'b1,
                 DIM_W'({pay[9], pay[8], pay[7]}) + 1'b1);
      end
    endcase
  endtask

  task automatic walk_byte(input logic [7:0] b);
    int need;
    case (phase)
      PH_FILE_HDR: begin
        // bytes 4..7 carry the file size, which plays no part
        if (idx < 4 || idx >= 8)
          tag = {tag[23:0], b};
        if (idx == 3 && tag != TAG_RIFF)
          conclude(ST_NOT_WEBP, '0, '0);
        else if (idx == 11) begin
          if (tag != TAG_WEBP)
            conclude(ST_NOT_WEBP, '0, '0);
          else
            open_chunk_header();
        end else
          idx++;
      end
      PH_CHUNK_HDR: begin
        if (idx < 4)
          tag = {tag[23:0], b};
        else
          clen = clen | (32'(b) << (8 * (idx - 5'd4)));
        if (idx < 7)
          idx++;
        else begin
          idx = '0;
          if (tag == TAG_VP8)
            phase = PH_VP8;
          else if (tag == TAG_VP8L)
            phase = PH_VP8L;
          else if (tag == TAG_VP8X)
            phase = PH_VP8X;
          else begin
            // odd sizes carry one pad byte
            skip_left = {1'b0, clen} + 33'(clen[0]);
            if (skip_left == '0)
              open_chunk_header();
            else
              phase = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (skip_left != '0)
          skip_left--;
        if (skip_left == '0)
          open_chunk_header();
      end
      PH_VP8, PH_VP8L, PH_VP8X: begin
        need = (phase == PH_VP8L) ? 5 : 10;
        if (idx < PAYLOAD_DEPTH)
          pay[idx] = b;
        idx++;
        if (idx >= need)
          close_payload();
      end
      default: ;
    endcase
  endtask

  task automatic step_parser(input logic [7:0] b, input logic last);
    dims_t short_buf;
    short_buf        = '0;
    short_buf.status = ST_TRUNCATED;
    if (seen < MIN_BYTES)
      seen++;
    if (!decided)
      walk_byte(b);
    // hold the decision back until enough of the buffer has arrived
    if (!reported) begin
      if (decided && seen >= MIN_BYTES) begin
        pending_dims = {pending_dims, held};
        reported = 1'b1;
      end else if (last)
        pending_dims = {pending_dims, short_buf};
    end
    if (last)
      clear_parser();
  endtask

  task automatic check_result(input logic [OUT_TDATA_W-1:0] d);
    dims_t want;
    dims_t got;
    got.status = d[1:0];
    got.width  = d[26:2];
    got.height = d[51:27];
    if (pending_dims.size() == 0) begin
      $error("unexpected result: status %0d width %0d height %0d",
             got.status, got.width, got.height);
      fails++;
    end else begin
      want = pending_dims.pop_front();
      if (got.status != want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fails++;
      end
      if (got.width != want.width) begin
        $error("width: expected %0d, actual %0d", want.width, got.width);
        fails++;
      end
      if (got.height != want.height) begin
        $error("height: expected %0d, actual %0d", want.height, got.height);
        fails++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parser();
    end else begin
      // take the request first so that a same-edge result still finds it
      if (s_axis_tvalid && s_axis_tready)
        step_parser(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready)
        check_result(m_axis_tdata);
    end
    fail_count   <= fails;
    dims_waiting <= pending_dims.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebP header dimension parser testbench
// Feeds whole buffers of bytes: hand-built corner files first, then random
// files, mostly well formed with random content, some noise or cut short.
// Both channels idle in random bursts; the checker scores the results.
// ----------------------------------------------------------------------------

module testbench;

  import whdp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;

  logic                   clk           = 1'b0;
  logic                   rst           = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [7:0]             s_axis_tdata  = '0;
  logic                   s_axis_tlast  = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int unsigned fail_count;
  int unsigned dims_waiting;
  int unsigned quiet_cycles = 0;
  int unsigned sent_bytes   = 0;
  int unsigned gap_pct      = 15;
  int unsigned stall_pct    = 15;
  bit          calm         = 1'b0;
  logic [7:0]  frame [$];

  always #4 clk = ~clk;

  webp_header_dims_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  whdp_dims_checker i_dims_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .dims_waiting  (dims_waiting)
  );

  // result side back-pressure
  always begin
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < stall_pct) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else if (quiet_cycles == QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  function automatic logic [13:0] rand14();
    return ($urandom_range(0, 15) == 0) ? 14'd0 : 14'($urandom);
  endfunction

  task automatic append_byte(input logic [7:0] v);
    frame = {frame, v};
  endtask

  task automatic add_tag(input logic [31:0] t);
    append_byte(t[31:24]);
    append_byte(t[23:16]);
    append_byte(t[15:8]);
    append_byte(t[7:0]);
  endtask

  task automatic add_le32(input logic [31:0] v);
    append_byte(v[7:0]);
    append_byte(v[15:8]);
    append_byte(v[23:16]);
    append_byte(v[31:24]);
  endtask

  task automatic add_noise(input int unsigned n);
    repeat (n) append_byte(8'($urandom));
  endtask

  task automatic add_file_head();
    add_tag(TAG_RIFF);
    add_le32($urandom);
    add_tag(TAG_WEBP);
  endtask

  task automatic add_other_chunk(input int unsigned size);
    add_tag($urandom);
    add_le32(size);
    add_noise(size + size % 2);
  endtask

  task automatic add_vp8(input logic [13:0] w14, input logic [13:0] h14, input bit start_ok);
    logic [7:0] s0;
    logic [7:0] s1;
    logic [7:0] s2;
    s0 = VP8_START0;
    s1 = VP8_START1;
    s2 = VP8_START2;
    if (!start_ok) begin
      case ($urandom_range(0, 2))
        0:       s0 ^= 8'($urandom_range(1, 255));
        1:       s1 ^= 8'($urandom_range(1, 255));
        default: s2 ^= 8'($urandom_range(1, 255));
      endcase
    end
    add_tag(TAG_VP8);
    add_le32($urandom);
    add_noise(3);
    append_byte(s0);
    append_byte(s1);
    append_byte(s2);
    // the top two bits of each high size byte are scale bits and must be dropped
    append_byte(w14[7:0]);
    append_byte({2'($urandom), w14[13:8]});
    append_byte(h14[7:0]);
    append_byte({2'($urandom), h14[13:8]});
  endtask

  task automatic add_vp8l(input logic [7:0] sig, input logic [31:0] bits);
    add_tag(TAG_VP8L);
    add_le32($urandom);
    append_byte(sig);
    add_le32(bits);
  endtask

  task automatic add_vp8x(input logic [23:0] w24, input logic [23:0] h24);
    add_tag(TAG_VP8X);
    add_le32($urandom);
    add_noise(4);
    append_byte(w24[7:0]);
    append_byte(w24[15:8]);
    append_byte(w24[23:16]);
    append_byte(h24[7:0]);
    append_byte(h24[15:8]);
    append_byte(h24[23:16]);
  endtask

  // enter and leave at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  task automatic send_frame();
    int n;
    n = frame.size();
    for (int i = 0; i < n; i++)
      send_byte(frame[i], i == n - 1);
    sent_bytes  += n;
    frame.delete();
  endtask

  task automatic make_random_frame();
    int kind;
    int pos;
    int cut;
    kind = $urandom_range(0, 9);
    if (kind <= 7) begin
      add_file_head();
      if (kind == 7) begin
        // corrupt one bit of either signature
        pos = $urandom_range(0, 7);
        if (pos >= 4)
          pos += 4;
        frame[pos] ^= 8'(1 << $urandom_range(0, 7));
      end
      repeat ($urandom_range(0, 2)) add_other_chunk($urandom_range(0, 12));
      case ($urandom_range(0, 2))
        0: add_vp8(rand14(), rand14(), $urandom_range(0, 7) != 0);
        1: add_vp8l(($urandom_range(0, 7) != 0) ? VP8L_SIG : 8'($urandom), $urandom);
        default: add_vp8x(($urandom_range(0, 7) == 0) ? 24'hff_ffff : 24'($urandom),
                          ($urandom_range(0, 7) == 0) ? 24'h00_0000 : 24'($urandom));
      endcase
      add_noise($urandom_range(0, 16));
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, frame.size());
        frame = frame[0:cut-1];
      end
    end else if (kind == 8) begin
      add_noise($urandom_range(1, 40));
    end else begin
      // an unknown chunk far longer than any buffer
      add_file_head();
      add_tag($urandom);
      add_le32(32'hffff_fff0 | $urandom_range(0, 15));
      add_noise($urandom_range(0, 24));
    end
  endtask

  task automatic run_directed();
    // lossless at full scale, padded up to the decision point
    add_file_head();
    add_vp8l(VP8L_SIG, 32'hffff_ffff);
    add_noise(5);
    send_frame();
    // a lossless file without padding: a short buffer beats the decision
    add_file_head();
    add_vp8l(VP8L_SIG, 32'h0000_0000);
    send_frame();
    // extended header at both extremes, with trailing bytes to drop
    add_file_head();
    add_vp8x(24'hff_ffff, 24'hff_ffff);
    add_noise(10);
    send_frame();
    add_file_head();
    add_vp8x(24'h00_0000, 24'h00_0000);
    add_noise(4);
    send_frame();
    // lossy at full scale, ending on the decision byte
    add_file_head();
    add_vp8(14'h3fff, 14'h3fff, 1'b1);
    send_frame();
    // lossy with a zero width, a zero height, a broken start code
    add_file_head();
    add_vp8(14'h0000, 14'h0001, 1'b1);
    add_noise(8);
    send_frame();
    add_file_head();
    add_vp8(14'h0001, 14'h0000, 1'b1);
    add_noise(8);
    send_frame();
    add_file_head();
    add_vp8(14'h0155, 14'h2aaa, 1'b0);
    add_noise(8);
    send_frame();
    // lossless with a wrong signature byte
    add_file_head();
    add_vp8l(8'hd0, $urandom);
    add_noise(5);
    send_frame();
    // neither RIFF nor WEBP
    add_tag(TAG_RIFF ^ 32'h0000_0001);
    add_noise(26);
    send_frame();
    add_tag(TAG_RIFF);
    add_le32($urandom);
    add_tag(TAG_WEBP ^ 32'h0000_0100);
    add_noise(18);
    send_frame();
    // a buffer of one byte
    append_byte(8'h52);
    send_frame();
    // empty and odd-sized chunks before the image
    add_file_head();
    add_other_chunk(0);
    add_other_chunk(3);
    add_vp8x(24'($urandom), 24'($urandom));
    send_frame();
    // buffer ends inside a chunk header
    add_file_head();
    add_other_chunk(12);
    add_tag(TAG_VP8);
    append_byte(8'h0a);
    send_frame();
    // buffer ends inside a skipped chunk of the largest size
    add_file_head();
    add_tag($urandom);
    add_le32(32'hffff_ffff);
    add_noise(20);
    send_frame();
    // buffer ends inside an image payload
    add_file_head();
    add_other_chunk(10);
    add_tag(TAG_VP8);
    add_le32(32'd10);
    add_noise(5);
    send_frame();
    // no image chunk at all
    add_file_head();
    add_other_chunk(9);
    add_other_chunk(4);
    send_frame();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    run_directed();
    while (sent_bytes < 1300) begin
      // drop all idling for the tail of the run
      if (sent_bytes >= 1100)
        calm = 1'b1;
      gap_pct   = pick_pct();
      stall_pct = pick_pct();
      make_random_frame();
      send_frame();
    end
    s_axis_tvalid <= 1'b0;
    while (dims_waiting != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (fail_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
